[rtl/mwt_pkg.sv]
// Shared types, codes and helpers for the watchpoint table.
`timescale 1ns / 1ps

package mwt_pkg;

   localparam logic [2:0] CMD_ACCESS = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_CHANGE = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [31:0] NOT_CACHED_BIT = 32'h4000_0000;
   localparam logic [31:0] MASK_RESET     = 32'h1FFF_FFFF;

   typedef struct packed {
      logic [31:0] start_addr;
      logic [31:0] end_addr;
      logic [2:0]  cond;
      logic [1:0]  action;
      logic [31:0] hits;
   } entry_type;

   // Item fields broadcast from the top level to every cell.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr_m;
      logic [4:0]  size;
      logic [31:0] lk_start;
      logic [31:0] lk_end;
      logic [31:0] mask;
      logic [31:0] new_start;
      logic [31:0] new_end;
      logic [2:0]  cond;
      logic [1:0]  action;
   } bcast_type;

   // Per-cell update strobes, valid only in the commit cycle.
   typedef struct packed {
      logic load;
      logic merge;
      logic change;
      logic shift;
      logic hit_inc;
   } cell_ctl_type;

   function automatic logic [31:0] strip(input logic [31:0] v);
      return v & ~NOT_CACHED_BIT;
   endfunction

endpackage

[rtl/memory_watchpoint_table_unit.sv]
// Watchpoint table top level: item capture, cell row, priority pick, result register.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | cmd, bounds/address, size, flags, bits
//   rsp_    | out       | rsp_valid/rsp_stall  | status, index, hit flags, hit total
//   csr_    | in        | csr_valid/csr_ready  | addr_mask write data
//
// An item passes through capture, an evaluate state where every cell registers
// its compare, and a commit cycle that picks the first matching cell and updates
// the row. The next item is taken in the cycle after commit.
// Synchronous reset empties the table and restores addr_mask; entry contents
// are not cleared. A stalled result holds commit until its register frees up.
`timescale 1ns / 1ps

module memory_watchpoint_table_unit import mwt_pkg::*; #(
   parameter int ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_addr_or_start,
   input  logic [31:0] req_range_end,
   input  logic [4:0]  req_access_size,
   input  logic        req_is_write,
   input  logic        req_deferred_path,
   input  logic [2:0]  req_cond_bits,
   input  logic [1:0]  req_action_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_entry_index,
   output logic        rsp_counted,
   output logic        rsp_break_req,
   output logic        rsp_change_pending,
   output logic [31:0] rsp_hit_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int UC_W  = $clog2(ENTRIES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] mask_ff;
   logic [UC_W-1:0] used_ff, used_in;

   logic [2:0]  cmd_ff;
   logic [31:0] addr_ff, end_ff;
   logic [4:0]  size_ff;
   logic        wr_ff, defer_ff;
   logic [2:0]  cond_ff;
   logic [1:0]  act_ff;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [2:0]  index_ff, index_in;
   logic        counted_ff, counted_in;
   logic        brk_ff, brk_in;
   logic        pend_ff, pend_in;
   logic [31:0] total_ff, total_in;

   bcast_type    bc;
   cell_ctl_type ctl [ENTRIES];
   entry_type    ent [ENTRIES];
   entry_type    nbr [ENTRIES];
   logic [ENTRIES-1:0] match, first;
   logic [ENTRIES-1:0] active;
   entry_type    sel;
   logic [IDX_W-1:0] idx;
   logic [IDX_W+2:0] idx_wide, used_wide;
   logic         found, can_out, commit, accept;
   logic         full, do_add_new, do_merge, do_remove, do_change, do_inc;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign can_out   = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_DONE) && can_out;
   assign csr_ready = 1'b1;

   always_comb begin
      bc.cmd       = cmd_ff;
      bc.addr_m    = addr_ff & mask_ff;
      bc.size      = size_ff;
      bc.lk_start  = addr_ff & mask_ff;
      bc.lk_end    = end_ff & mask_ff;
      bc.mask      = mask_ff;
      bc.new_start = addr_ff;
      bc.new_end   = end_ff;
      bc.cond      = cond_ff;
      bc.action    = act_ff;
   end

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         if (g == ENTRIES - 1) begin : g_last
            assign nbr[g] = ent[g];
         end else begin : g_mid
            assign nbr[g] = ent[g + 1];
         end
         assign active[g] = (UC_W'(g) < used_ff);
         mwt_cell u_cell (
            .clock   (clock),
            .active  (active[g]),
            .eval_en (state_ff == ST_EVAL),
            .bc      (bc),
            .ctl     (ctl[g]),
            .nbr     (nbr[g]),
            .ent     (ent[g]),
            .match   (match[g])
         );
      end
   endgenerate

   // First matching cell wins.
   assign first = match & (~match + ENTRIES'(1));
   assign found = |match;

   always_comb begin
      sel = '0;
      idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (first[i]) begin
            sel = sel | ent[i];
            idx = idx | IDX_W'(i);
         end
      end
   end

   assign idx_wide  = {3'd0, idx};
   assign used_wide = (IDX_W + 3)'(used_ff);
   assign full      = (used_ff >= UC_W'(ENTRIES));

   always_comb begin
      do_add_new = 1'b0;
      do_merge   = 1'b0;
      do_remove  = 1'b0;
      do_change  = 1'b0;
      do_inc     = 1'b0;
      status_in  = STATUS_NOTFOUND;
      index_in   = 3'd0;
      counted_in = 1'b0;
      brk_in     = 1'b0;
      pend_in    = 1'b0;
      total_in   = 32'd0;
      used_in    = used_ff;
      case (cmd_ff)
         CMD_ACCESS: begin
            if (found) begin
               status_in = STATUS_OK;
               index_in  = idx_wide[2:0];
               if (defer_ff && wr_ff && (sel.cond[2:1] == 2'b11)) begin
                  pend_in = 1'b1;
               end else if (wr_ff ? sel.cond[1] : sel.cond[0]) begin
                  counted_in = 1'b1;
                  brk_in     = sel.action[1];
                  do_inc     = 1'b1;
               end
               total_in = sel.hits + {31'd0, counted_in};
            end
         end
         CMD_ADD: begin
            if (found) begin
               do_merge  = 1'b1;
               status_in = STATUS_OK;
               index_in  = idx_wide[2:0];
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               do_add_new = 1'b1;
               status_in  = STATUS_OK;
               index_in   = used_wide[2:0];
               used_in    = used_ff + UC_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               do_remove = 1'b1;
               status_in = STATUS_OK;
               index_in  = idx_wide[2:0];
               used_in   = used_ff - UC_W'(1);
            end
         end
         CMD_CHANGE: begin
            if (found) begin
               do_change = 1'b1;
               status_in = STATUS_OK;
               index_in  = idx_wide[2:0];
            end
         end
         CMD_CLEAR: begin
            status_in = STATUS_OK;
            used_in   = '0;
         end
         default: begin
            status_in = STATUS_NOTFOUND;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ctl[i].load    = commit && do_add_new && (UC_W'(i) == used_ff);
         ctl[i].merge   = commit && do_merge && first[i];
         ctl[i].change  = commit && do_change && first[i];
         ctl[i].hit_inc = commit && do_inc && first[i];
         // Cells at and above the removed one take their upper neighbor.
         ctl[i].shift   = commit && do_remove && (IDX_W'(i) >= idx);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (can_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= MASK_RESET;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_wdata;
         end
         if (commit) begin
            used_ff      <= used_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         addr_ff  <= req_addr_or_start;
         end_ff   <= req_range_end;
         size_ff  <= req_access_size;
         wr_ff    <= req_is_write;
         defer_ff <= req_deferred_path;
         cond_ff  <= req_cond_bits;
         act_ff   <= req_action_bits;
      end
      if (commit) begin
         status_ff  <= status_in;
         index_ff   <= index_in;
         counted_ff <= counted_in;
         brk_ff     <= brk_in;
         pend_ff    <= pend_in;
         total_ff   <= total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_entry_index    = index_ff;
   assign rsp_counted        = counted_ff;
   assign rsp_break_req      = brk_ff;
   assign rsp_change_pending = pend_ff;
   assign rsp_hit_total      = total_ff;

endmodule

[rtl/mwt_cell.sv]
// One watchpoint entry: storage, local compare and neighbor shift.
`timescale 1ns / 1ps

module mwt_cell import mwt_pkg::*; (
   input  logic         clock,
   input  logic         active,
   input  logic         eval_en,
   input  bcast_type    bc,
   input  cell_ctl_type ctl,
   input  entry_type    nbr,
   output entry_type    ent,
   output logic         match
);

   entry_type ent_ff, ent_in;
   logic      match_ff, match_in;
   logic [31:0] s_st, e_st, a_st, sum_st;
   logic        acc_hit, lk_hit;

   always_comb begin
      s_st    = strip(ent_ff.start_addr);
      e_st    = strip(ent_ff.end_addr);
      a_st    = strip(bc.addr_m);
      sum_st  = strip(bc.addr_m + {27'd0, bc.size});
      if (ent_ff.end_addr != 32'd0) begin
         acc_hit = (sum_st > s_st) && (a_st < e_st);
      end else begin
         acc_hit = (s_st == a_st);
      end
      lk_hit  = ((ent_ff.start_addr & bc.mask) == bc.lk_start) &&
                ((ent_ff.end_addr & bc.mask) == bc.lk_end);
      match_in = active && ((bc.cmd == CMD_ACCESS) ? acc_hit : lk_hit);
   end

   always_comb begin
      ent_in = ent_ff;
      if (ctl.load) begin
         ent_in.start_addr = bc.new_start;
         ent_in.end_addr   = bc.new_end;
         ent_in.cond       = bc.cond;
         ent_in.action     = bc.action;
         ent_in.hits       = 32'd0;
      end else if (ctl.shift) begin
         ent_in = nbr;
      end else begin
         if (ctl.merge) begin
            ent_in.cond   = ent_ff.cond | bc.cond;
            ent_in.action = ent_ff.action | bc.action;
         end
         if (ctl.change) begin
            ent_in.cond   = bc.cond;
            ent_in.action = bc.action;
         end
         if (ctl.hit_inc) begin
            ent_in.hits = ent_ff.hits + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      if (eval_en) begin
         match_ff <= match_in;
      end
   end

   assign ent   = ent_ff;
   assign match = match_ff;

endmodule

[tb/sv/memory_watchpoint_table_checker.sv]
// Checker for the watchpoint table: tracks table state, predicts each result beat and compares.
`timescale 1ns / 1ps

module memory_watchpoint_table_checker import mwt_pkg::*; #(
   parameter int ENTRIES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [31:0] req_addr_or_start,
   input  logic [31:0] req_range_end,
   input  logic [4:0]  req_access_size,
   input  logic        req_is_write,
   input  logic        req_deferred_path,
   input  logic [2:0]  req_cond_bits,
   input  logic [1:0]  req_action_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_status,
   input  logic [2:0]  rsp_entry_index,
   input  logic        rsp_counted,
   input  logic        rsp_break_req,
   input  logic        rsp_change_pending,
   input  logic [31:0] rsp_hit_total,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          results_owed
);

   localparam logic [31:0] KEEP_CACHED = ~NOT_CACHED_BIT;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  index;
      logic        counted;
      logic        break_req;
      logic        change_pending;
      logic [31:0] hit_total;
   } watch_result_type;

   logic [31:0]      addr_mask_q;
   int               used_entries;
   logic [31:0]      wp_start  [ENTRIES];
   logic [31:0]      wp_end    [ENTRIES];
   logic [2:0]       wp_cond   [ENTRIES];
   logic [1:0]       wp_action [ENTRIES];
   logic [31:0]      wp_hits   [ENTRIES];
   watch_result_type expected_results[$];
   int               errors = 0;

   assign mismatch_count = errors;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (errors < 100)
         $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      errors++;
   endtask

   // Lookup for table commands: both sides masked, bit 30 kept.
   function automatic int find_bounds(input logic [31:0] s, input logic [31:0] e);
      for (int i = 0; i < used_entries; i++) begin
         if ((wp_start[i] & addr_mask_q) == (s & addr_mask_q) &&
             (wp_end[i] & addr_mask_q) == (e & addr_mask_q))
            return i;
      end
      return -1;
   endfunction

   task automatic predict_watch_result(input logic [2:0] cmd, input logic [31:0] addr,
                                       input logic [31:0] range_end, input logic [4:0] size,
                                       input logic wr, input logic deferred,
                                       input logic [2:0] cond, input logic [1:0] action,
                                       output watch_result_type r);
      int          found;
      logic [31:0] ad;
      logic [31:0] span_end;
      logic        hit;
      r = '0;
      r.status = STATUS_NOTFOUND;
      found = -1;
      case (cmd)
         CMD_ACCESS: begin
            ad = addr & addr_mask_q;
            span_end = ad + {27'd0, size};
            for (int i = 0; i < used_entries; i++) begin
               if (found < 0) begin
                  if (wp_end[i] != 32'd0)
                     hit = ((span_end & KEEP_CACHED) > (wp_start[i] & KEEP_CACHED)) &&
                           ((ad & KEEP_CACHED) < (wp_end[i] & KEEP_CACHED));
                  else
                     hit = (wp_start[i] & KEEP_CACHED) == (ad & KEEP_CACHED);
                  if (hit)
                     found = i;
               end
            end
            if (found >= 0) begin
               r.status = STATUS_OK;
               r.index = found[2:0];
               if (deferred && wr && wp_cond[found][2:1] == 2'b11) begin
                  r.change_pending = 1'b1;
               end else if (wr ? wp_cond[found][1] : wp_cond[found][0]) begin
                  wp_hits[found] = wp_hits[found] + 32'd1;
                  r.counted = 1'b1;
                  r.break_req = wp_action[found][1];
               end
               r.hit_total = wp_hits[found];
            end
         end
         CMD_ADD: begin
            found = find_bounds(addr, range_end);
            if (found >= 0) begin
               wp_cond[found] |= cond;
               wp_action[found] |= action;
               r.status = STATUS_OK;
               r.index = found[2:0];
            end else if (used_entries >= ENTRIES) begin
               r.status = STATUS_FULL;
            end else begin
               wp_start[used_entries] = addr;
               wp_end[used_entries] = range_end;
               wp_cond[used_entries] = cond;
               wp_action[used_entries] = action;
               wp_hits[used_entries] = 32'd0;
               r.status = STATUS_OK;
               r.index = used_entries[2:0];
               used_entries++;
            end
         end
         CMD_REMOVE: begin
            found = find_bounds(addr, range_end);
            if (found >= 0) begin
               for (int j = found; j + 1 < used_entries; j++) begin
                  wp_start[j] = wp_start[j + 1];
                  wp_end[j] = wp_end[j + 1];
                  wp_cond[j] = wp_cond[j + 1];
                  wp_action[j] = wp_action[j + 1];
                  wp_hits[j] = wp_hits[j + 1];
               end
               used_entries--;
               r.status = STATUS_OK;
               r.index = found[2:0];
            end
         end
         CMD_CHANGE: begin
            found = find_bounds(addr, range_end);
            if (found >= 0) begin
               wp_cond[found] = cond;
               wp_action[found] = action;
               r.status = STATUS_OK;
               r.index = found[2:0];
            end
         end
         CMD_CLEAR: begin
            used_entries = 0;
            r.status = STATUS_OK;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      watch_result_type want;
      watch_result_type got;
      if (reset) begin
         addr_mask_q = MASK_RESET;
         used_entries = 0;
         expected_results.delete();
         results_owed <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_entry_index, rsp_counted, rsp_break_req,
                    rsp_change_pending, rsp_hit_total};
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing expected, status", 32'd0,
                               32'(got.status));
            end else begin
               want = expected_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", 32'(want.status), 32'(got.status));
               if (got.index != want.index)
                  report_mismatch("entry_index", 32'(want.index), 32'(got.index));
               if (got.counted != want.counted)
                  report_mismatch("counted", 32'(want.counted), 32'(got.counted));
               if (got.break_req != want.break_req)
                  report_mismatch("break_req", 32'(want.break_req), 32'(got.break_req));
               if (got.change_pending != want.change_pending)
                  report_mismatch("change_pending", 32'(want.change_pending),
                                  32'(got.change_pending));
               if (got.hit_total != want.hit_total)
                  report_mismatch("hit_total", want.hit_total, got.hit_total);
            end
         end
         if (csr_valid && csr_ready)
            addr_mask_q = csr_wdata;
         if (req_valid && !req_stall) begin
            predict_watch_result(req_cmd, req_addr_or_start, req_range_end, req_access_size,
                                 req_is_write, req_deferred_path, req_cond_bits,
                                 req_action_bits, want);
            expected_results.insert(expected_results.size(), want);
         end
         results_owed <= expected_results.size();
      end
   end

endmodule

[tb/sv/memory_watchpoint_table_unit_test.sv]
// Testbench top for the watchpoint table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module memory_watchpoint_table_unit_test import mwt_pkg::*;;

   localparam logic [2:0] CMD_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNDEF_LAST  = 3'd7;
   localparam int         POOL_DEPTH      = 16;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr_or_start;
      logic [31:0] range_end;
      logic [4:0]  access_size;
      logic        is_write;
      logic        deferred_path;
      logic [2:0]  cond_bits;
      logic [1:0]  action_bits;
   } watch_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_ACCESS;
   logic [31:0] req_addr_or_start = '0;
   logic [31:0] req_range_end = '0;
   logic [4:0]  req_access_size = '0;
   logic        req_is_write = 1'b0;
   logic        req_deferred_path = 1'b0;
   logic [2:0]  req_cond_bits = '0;
   logic [1:0]  req_action_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_entry_index;
   logic        rsp_counted;
   logic        rsp_break_req;
   logic        rsp_change_pending;
   logic [31:0] rsp_hit_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_wdata = '0;
   int          mismatch_count;
   int          results_owed;

   logic [31:0] cur_mask = MASK_RESET;
   logic [31:0] pool_start [POOL_DEPTH];
   logic [31:0] pool_end   [POOL_DEPTH];
   int          pool_count = 0;
   int          pool_next = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b0;
   logic [31:0] stall_bits = '0;
   logic [5:0]  stall_tick = '0;

   always #5 clock = ~clock;

   memory_watchpoint_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_addr_or_start(req_addr_or_start),
      .req_range_end(req_range_end), .req_access_size(req_access_size),
      .req_is_write(req_is_write), .req_deferred_path(req_deferred_path),
      .req_cond_bits(req_cond_bits), .req_action_bits(req_action_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_entry_index(rsp_entry_index),
      .rsp_counted(rsp_counted), .rsp_break_req(rsp_break_req),
      .rsp_change_pending(rsp_change_pending), .rsp_hit_total(rsp_hit_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   memory_watchpoint_table_checker watch_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_addr_or_start(req_addr_or_start),
      .req_range_end(req_range_end), .req_access_size(req_access_size),
      .req_is_write(req_is_write), .req_deferred_path(req_deferred_path),
      .req_cond_bits(req_cond_bits), .req_action_bits(req_action_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_entry_index(rsp_entry_index),
      .rsp_counted(rsp_counted), .rsp_break_req(rsp_break_req),
      .rsp_change_pending(rsp_change_pending), .rsp_hit_total(rsp_hit_total),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .results_owed(results_owed)
   );

   // Result-side stall: a 32-bit pattern rotated each cycle, reloaded when the 6-bit tick counter wraps to zero.
   always @(posedge clock) begin
      if (reset) begin
         stall_bits <= '0;
         stall_tick <= '0;
         rsp_stall <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 6'd1;
         if (stall_tick == 6'd0) begin
            case ($urandom_range(0, 3))
               0: stall_bits <= '0;
               1: stall_bits <= $urandom;
               2: stall_bits <= $urandom & $urandom;
               default: stall_bits <= $urandom | $urandom;
            endcase
         end else begin
            stall_bits <= {stall_bits[30:0], stall_bits[31]};
         end
         rsp_stall <= stall_bits[0];
      end
   end

   function automatic watch_req_type table_cmd(input logic [2:0] cmd, input logic [31:0] s,
                                               input logic [31:0] e, input logic [2:0] cond,
                                               input logic [1:0] action);
      watch_req_type it;
      it = '0;
      it.cmd = cmd;
      it.addr_or_start = s;
      it.range_end = e;
      it.cond_bits = cond;
      it.action_bits = action;
      return it;
   endfunction

   function automatic watch_req_type access_item(input logic [31:0] a, input logic [4:0] size,
                                                 input logic wr, input logic deferred);
      watch_req_type it;
      it = '0;
      it.cmd = CMD_ACCESS;
      it.addr_or_start = a;
      it.access_size = size;
      it.is_write = wr;
      it.deferred_path = deferred;
      return it;
   endfunction

   // Randomly toggle bit 30 and set bits that the mask throws away.
   function automatic logic [31:0] dress_addr(input logic [31:0] v);
      if ($urandom_range(0, 3) == 0)
         v ^= NOT_CACHED_BIT;
      if ($urandom_range(0, 3) == 0)
         v |= $urandom & ~cur_mask;
      return v;
   endfunction

   task automatic drive_item(input watch_req_type it);
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_addr_or_start <= it.addr_or_start;
      req_range_end <= it.range_end;
      req_access_size <= it.access_size;
      req_is_write <= it.is_write;
      req_deferred_path <= it.deferred_path;
      req_cond_bits <= it.cond_bits;
      req_action_bits <= it.action_bits;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off the sender until every result beat has come back.
   task automatic settle_table();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic csr_write_mask(input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_mask = value;
   endtask

   task automatic maybe_gap();
      if (burst_left == 0) begin
         if (gaps_on) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
   endtask

   task automatic make_random_item(output watch_req_type it);
      int          roll;
      int          k;
      logic [31:0] s;
      logic [31:0] e;
      roll = $urandom_range(0, 99);
      it.cmd = CMD_ACCESS;
      it.addr_or_start = $urandom;
      it.range_end = $urandom;
      it.access_size = 5'($urandom_range(0, 31));
      it.is_write = 1'($urandom_range(0, 1));
      it.deferred_path = 1'($urandom_range(0, 1));
      it.cond_bits = 3'($urandom_range(0, 7));
      it.action_bits = 2'($urandom_range(0, 3));
      k = (pool_count > 0) ? $urandom_range(0, pool_count - 1) : 0;
      s = pool_start[k];
      e = pool_end[k];
      if (roll < 8) begin
         it.cmd = 3'($urandom_range(0, 7));
      end else if (pool_count == 0 || roll < 25) begin
         s = 32'h0000_1000 + $urandom_range(0, 511);
         if ($urandom_range(0, 15) == 0)
            s = $urandom;
         case ($urandom_range(0, 7))
            0, 1: e = '0;
            2: e = $urandom;
            default: e = s + $urandom_range(1, 48);
         endcase
         it.cmd = CMD_ADD;
         it.addr_or_start = s;
         it.range_end = e;
         pool_start[pool_next] = s;
         pool_end[pool_next] = e;
         pool_next = (pool_next + 1) % POOL_DEPTH;
         if (pool_count < POOL_DEPTH)
            pool_count++;
      end else if (roll < 65) begin
         if ($urandom_range(0, 3) != 0)
            it.access_size = 5'($urandom_range(1, 8));
         if (e == '0) begin
            it.addr_or_start = s;
         end else begin
            // probe both sides of each range boundary
            case ($urandom_range(0, 4))
               0: it.addr_or_start = s - {27'd0, it.access_size};
               1: it.addr_or_start = s - {27'd0, it.access_size} + 32'd1;
               2: it.addr_or_start = e - 32'd1;
               3: it.addr_or_start = e;
               default: it.addr_or_start = s + $urandom_range(0, (e > s) ? e - s : 0);
            endcase
         end
         it.addr_or_start = dress_addr(it.addr_or_start);
      end else begin
         if (roll < 75)
            it.cmd = CMD_ADD;
         else if (roll < 85)
            it.cmd = CMD_REMOVE;
         else if (roll < 95)
            it.cmd = CMD_CHANGE;
         else if (roll < 97)
            it.cmd = CMD_CLEAR;
         it.addr_or_start = (it.cmd == CMD_CLEAR) ? it.addr_or_start : dress_addr(s);
         it.range_end = (it.cmd == CMD_CLEAR) ? it.range_end : e;
      end
   endtask

   task automatic run_phase(input logic [31:0] mask, input int count, input bit with_gaps);
      watch_req_type it;
      settle_table();
      csr_write_mask(mask);
      gaps_on = with_gaps;
      burst_left = 0;
      repeat (count) begin
         maybe_gap();
         make_random_item(it);
         drive_item(it);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, not-found paths
      drive_item(access_item(32'h0000_0100, 5'd4, 1'b0, 1'b0));
      drive_item(table_cmd(CMD_REMOVE, 32'h0000_0100, 32'd0, 3'd0, 2'd0));
      // single-address entry, bit 30 and bits above the mask ignored
      drive_item(table_cmd(CMD_ADD, 32'h0000_0100, 32'd0, 3'b011, 2'b10));
      drive_item(access_item(32'h0000_0100, 5'd4, 1'b0, 1'b0));
      drive_item(access_item(32'hE000_0100, 5'd0, 1'b1, 1'b0));
      // range entry with write-on-change: deferred write only flags
      drive_item(table_cmd(CMD_ADD, 32'h0000_0200, 32'h0000_0210, 3'b111, 2'b01));
      drive_item(access_item(32'h0000_020C, 5'd4, 1'b1, 1'b1));
      drive_item(access_item(32'h0000_020C, 5'd4, 1'b1, 1'b0));
      drive_item(access_item(32'h0000_01FC, 5'd4, 1'b0, 1'b0));
      drive_item(access_item(32'h0000_01FC, 5'd5, 1'b0, 1'b0));
      drive_item(access_item(32'h0000_0210, 5'd16, 1'b0, 1'b0));
      // add on existing bounds merges, then change overwrites
      drive_item(table_cmd(CMD_ADD, 32'h4000_0200, 32'h0000_0210, 3'b000, 2'b10));
      drive_item(table_cmd(CMD_CHANGE, 32'h0000_0200, 32'h0000_0210, 3'b001, 2'b00));
      drive_item(access_item(32'h0000_0200, 5'd2, 1'b1, 1'b0));
      // fill the table, then one more add
      drive_item(table_cmd(CMD_ADD, 32'h0000_0300, 32'h0000_0310, 3'b001, 2'b11));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0400, 32'd0, 3'b010, 2'b00));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0500, 32'h0000_0501, 3'b100, 2'b01));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0600, 32'h0000_06FF, 3'b110, 2'b10));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0700, 32'hFFFF_FFFF, 3'b101, 2'b11));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0800, 32'd0, 3'b111, 2'b11));
      drive_item(table_cmd(CMD_ADD, 32'h0000_0900, 32'd0, 3'b011, 2'b11));
      // remove from the middle shifts the rest down
      drive_item(table_cmd(CMD_REMOVE, 32'h0000_0200, 32'h0000_0210, 3'd0, 2'd0));
      drive_item(access_item(32'h0000_0305, 5'd1, 1'b0, 1'b0));
      drive_item(table_cmd(CMD_UNDEF_FIRST, $urandom, $urandom, 3'b111, 2'b11));
      drive_item(table_cmd(CMD_UNDEF_LAST, $urandom, $urandom, 3'b111, 2'b11));
      drive_item(table_cmd(CMD_CLEAR, 32'h0000_0100, 32'd0, 3'd0, 2'd0));
      drive_item(access_item(32'h0000_0100, 5'd31, 1'b0, 1'b0));

      run_phase(32'hFFFF_FFFF, 250, 1'b0);
      run_phase(32'h0000_0000, 120, 1'b1);
      run_phase(32'h0000_FFFF, 200, 1'b1);
      run_phase($urandom, 230, 1'b1);
      run_phase(MASK_RESET, 300, 1'b1);

      settle_table();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("memory_watchpoint_table_unit_test OK");
      else
         $display("memory_watchpoint_table_unit_test NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("memory_watchpoint_table_unit_test NOT OK");
      $finish;
   end

endmodule
